// ===== rtl/smrp_pkg.sv =====
package smrp_pkg;

    // Characters of the report body.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PRESS   = 8'h4D;
    localparam logic [7:0] CH_RELEASE = 8'h6D;

    // Button codes that produce an event.
    localparam logic [7:0] BTN_LEFT       = 8'd0;
    localparam logic [7:0] BTN_MIDDLE     = 8'd1;
    localparam logic [7:0] BTN_RIGHT      = 8'd2;
    localparam logic [7:0] BTN_WHEEL_UP   = 8'd64;
    localparam logic [7:0] BTN_WHEEL_DOWN = 8'd65;

    // Saturation limits of the decimal fields.
    localparam logic [15:0] BUTTON_LIMIT = 16'd255;
    localparam logic [15:0] POS_LIMIT    = 16'hFFFF;

    // Event kinds on the result channel.
    typedef enum logic [2:0] {
        EV_LEFT_PRESS      = 3'd0,
        EV_LEFT_RELEASE    = 3'd1,
        EV_MIDDLE_PRESS    = 3'd2,
        EV_MIDDLE_RELEASE  = 3'd3,
        EV_RIGHT_PRESS     = 3'd4,
        EV_RIGHT_RELEASE   = 3'd5,
        EV_WHEEL_UP        = 3'd6,
        EV_WHEEL_DOWN      = 3'd7
    } t_event_kind;

    // Field currently being filled.
    typedef enum logic [1:0] {
        FLD_BUTTON = 2'd0,
        FLD_X      = 2'd1,
        FLD_Y      = 2'd2,
        FLD_DONE   = 2'd3
    } t_field;

    // One decimal step: acc * 10 + digit, clipped at limit.
    function automatic logic [15:0] sat_acc(input logic [15:0] acc,
                                            input logic [3:0]  digit,
                                            input logic [15:0] limit);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, digit};
        if (v > {4'd0, limit}) begin
            return limit;
        end
        return v[15:0];
    endfunction

endpackage

// ===== rtl/sgr_mouse_report_parser.sv =====
// Mouse report body parser.
//
// Input channel: one body byte per request on i_byte_in (i_in_valid /
// o_in_ready). Output channel: one event per request on o_event_kind,
// o_x_pos and o_y_pos (o_out_valid / i_out_ready). Only the terminating
// 'M' or 'm' of a report with a known button code makes an event; every
// other byte is absorbed into the parse state.
//
// A byte is decoded from the input register; a terminator's event enters
// the result register as that byte moves on. One byte per cycle is taken
// while the result register is free or draining: the held byte drains into
// the parse state and the result register in the same cycle.
//
// Reset clears the parse state, the byte counter and both valid flags.
// While the receiver holds off an event, the input register keeps one byte
// and o_in_ready drops until the result is taken.
// A report that reaches REPORT_MAX_BYTES bytes without a terminator is
// discarded with no event.
module sgr_mouse_report_parser #(
    parameter int REPORT_MAX_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_x_pos,
    output logic [15:0] o_y_pos
);
    import smrp_pkg::*;

    localparam int         CNT_W   = $clog2(REPORT_MAX_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(REPORT_MAX_BYTES);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_byte;

    // Parse state.
    t_field           r_field,  n_field;
    logic             r_digit,  n_digit;
    logic             r_halt,   n_halt;
    logic [7:0]       r_button, n_button;
    logic [15:0]      r_x,      n_x;
    logic [15:0]      r_y,      n_y;
    logic [CNT_W-1:0] r_count,  n_count;

    // Result register.
    logic        r_out_valid;
    t_event_kind r_kind;
    logic [15:0] r_x_pos;
    logic [15:0] r_y_pos;

    logic        fire;
    logic        is_term;
    logic        is_digit;
    logic        is_sep;
    logic        emit;
    t_event_kind kind;
    logic [15:0] acc_in;
    logic [15:0] acc_out;
    logic [15:0] acc_limit;

    // The held byte moves on when the result register is free or draining.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    assign is_term  = (r_byte == CH_PRESS) || (r_byte == CH_RELEASE);
    assign is_digit = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign is_sep   = (r_byte == CH_SPACE) || (r_byte == CH_SEMI);

    // Select the field the digit goes into and share one accumulator.
    always_comb begin
        acc_in    = r_x;
        acc_limit = POS_LIMIT;
        case (r_field)
            FLD_BUTTON: begin
                acc_in    = {8'd0, r_button};
                acc_limit = BUTTON_LIMIT;
            end
            FLD_Y:   acc_in = r_y;
            default: acc_in = r_x;
        endcase
    end

    assign acc_out = sat_acc(acc_in, r_byte[3:0], acc_limit);

    // Button code and terminator to event kind.
    always_comb begin
        emit = 1'b1;
        kind = EV_LEFT_PRESS;
        unique case (r_button)
            BTN_LEFT:       kind = (r_byte == CH_RELEASE) ? EV_LEFT_RELEASE
                                                          : EV_LEFT_PRESS;
            BTN_MIDDLE:     kind = (r_byte == CH_RELEASE) ? EV_MIDDLE_RELEASE
                                                          : EV_MIDDLE_PRESS;
            BTN_RIGHT:      kind = (r_byte == CH_RELEASE) ? EV_RIGHT_RELEASE
                                                          : EV_RIGHT_PRESS;
            BTN_WHEEL_UP:   kind = EV_WHEEL_UP;
            BTN_WHEEL_DOWN: kind = EV_WHEEL_DOWN;
            default:        emit = 1'b0;
        endcase
    end

    // Next parse state for the held byte.
    always_comb begin
        n_field  = r_field;
        n_digit  = r_digit;
        n_halt   = r_halt;
        n_button = r_button;
        n_x      = r_x;
        n_y      = r_y;
        n_count  = r_count + 1'b1;
        if (!is_term && !r_halt && (r_field != FLD_DONE)) begin
            if (is_digit) begin
                case (r_field)
                    FLD_BUTTON: n_button = acc_out[7:0];
                    FLD_Y:      n_y      = acc_out;
                    default:    n_x      = acc_out;
                endcase
                n_digit = 1'b1;
            end else if (is_sep) begin
                if (r_digit) begin
                    n_field = t_field'(r_field + 2'd1);
                    n_digit = 1'b0;
                end
            end else begin
                n_halt = 1'b1;
            end
        end
        // A terminator or a full buffer starts a fresh report.
        if (is_term || (n_count == MAX_CNT)) begin
            n_field  = FLD_BUTTON;
            n_digit  = 1'b0;
            n_halt   = 1'b0;
            n_button = '0;
            n_x      = '0;
            n_y      = '0;
            n_count  = '0;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_byte_in;
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field  <= FLD_BUTTON;
            r_digit  <= 1'b0;
            r_halt   <= 1'b0;
            r_button <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_count  <= '0;
        end else if (fire) begin
            r_field  <= n_field;
            r_digit  <= n_digit;
            r_halt   <= n_halt;
            r_button <= n_button;
            r_x      <= n_x;
            r_y      <= n_y;
            r_count  <= n_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= is_term && emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire && is_term && emit) begin
            r_kind  <= kind;
            r_x_pos <= r_x;
            r_y_pos <= r_y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_x_pos      = r_x_pos;
    assign o_y_pos      = r_y_pos;

    // The byte counter is cleared before it can reach the buffer size.
    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < MAX_CNT)
        else $error("byte counter reached the buffer size");

    // A terminator always leaves a fresh report behind.
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && is_term |=> (r_field == FLD_BUTTON) && (r_count == '0)
                            && !r_halt && !r_digit)
        else $error("report state not cleared after terminator");

    // Digits are only recorded while a field is still open.
    a_digit_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit |-> (r_field != FLD_DONE))
        else $error("digit flag set after the last field");

    // An event is only raised by a terminator.
    a_event_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(fire && is_term))
        else $error("event raised without a terminator");

endmodule
